// File: hw/rtl/bftr_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap font text renderer package
// Shared constants, register indexes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
`default_nettype none

package bftr_pkg;

	localparam int FONT_BYTES = 4096;
	localparam int FONT_AW    = $clog2(FONT_BYTES);
	localparam int GLYPH_ROWS = 16;
	localparam int ROW_W      = $clog2(GLYPH_ROWS);
	localparam int GLYPH_COLS = 8;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 32;

	localparam logic [CFG_IW-1:0] REG_COLOUR       = 2'd0;
	localparam logic [CFG_IW-1:0] REG_SCREEN_WIDTH = 2'd1;
	localparam logic [CFG_IW-1:0] REG_LINE_STRIDE  = 2'd2;
	localparam logic [CFG_IW-1:0] REG_GLYPH_STRIDE = 2'd3;

	localparam logic [31:0] COLOUR_RESET       = 32'h0000_9f3b;
	localparam logic [15:0] SCREEN_WIDTH_RESET = 16'd640;
	localparam logic [15:0] LINE_STRIDE_RESET  = 16'd640;
	localparam logic [7:0]  GLYPH_STRIDE_RESET = 8'd16;

	localparam logic       OP_FONT_WRITE = 1'b0;
	localparam logic       OP_DRAW       = 1'b1;
	localparam logic [7:0] CHAR_NEWLINE  = 8'd10;

	typedef struct packed {
		logic font_wr;
		logic newline;
		logic capture;
		logic setup;
		logic issue;
	} bftr_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic row_last;
	} bftr_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/bftr_channels.sv
// ----------------------------------------------------------------------------
// Bitmap font text renderer channels
// Valid/ready interfaces for the input item and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bftr_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  character;
	logic [11:0] font_address;
	logic [7:0]  font_byte;

	modport source (output valid, output opcode, output character,
		output font_address, output font_byte, input ready);
	modport sink (input valid, input opcode, input character,
		input font_address, input font_byte, output ready);
endinterface

interface bftr_out_if;
	logic        valid;
	logic        ready;
	logic [23:0] pixel_index;
	logic [7:0]  pixel_mask;
	logic [31:0] pixel_colour;
	logic        last_row;

	modport source (output valid, output pixel_index, output pixel_mask,
		output pixel_colour, output last_row, input ready);
	modport sink (input valid, input pixel_index, input pixel_mask,
		input pixel_colour, input last_row, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bftr_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap font text renderer controller
// Decodes accepted items and sequences the glyph row reads.
// ----------------------------------------------------------------------------
`default_nettype none

module bftr_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  in_opcode,
	input  wire logic [7:0]            in_character,
	input  wire bftr_pkg::bftr_status_t status,
	output bftr_pkg::bftr_cmd_t        cmd
);
	import bftr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SETUP,
		S_ROWS
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_opcode == OP_FONT_WRITE) begin
						cmd.font_wr = 1'b1;
					end else if (in_character == CHAR_NEWLINE) begin
						cmd.newline = 1'b1;
					end else begin
						cmd.capture = 1'b1;
					end
				end
			end
			S_SETUP: cmd.setup = 1'b1;
			S_ROWS:  cmd.issue = status.slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && in_opcode == OP_DRAW && in_character != CHAR_NEWLINE) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: state_q <= S_ROWS;
				S_ROWS: begin
					if (status.slot_free && status.row_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/bftr_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap font text renderer datapath
// Configuration, cursor, font store, row read stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bftr_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bftr_pkg::bftr_cmd_t           cmd,
	output bftr_pkg::bftr_status_t             status,
	input  wire logic                          cfg_we,
	input  wire logic [bftr_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [bftr_pkg::CFG_DW-1:0]   cfg_data,
	input  wire logic [7:0]                    in_character,
	input  wire logic [11:0]                   in_font_address,
	input  wire logic [7:0]                    in_font_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [23:0]                        out_pixel_index,
	output logic [7:0]                         out_pixel_mask,
	output logic [31:0]                        out_pixel_colour,
	output logic                               out_last_row
);
	import bftr_pkg::*;

	logic [31:0] colour_q;
	logic [15:0] screen_width_q;
	logic [15:0] line_stride_q;
	logic [7:0]  glyph_stride_q;

	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [15:0] x_adv;

	logic [7:0]  char_q;
	logic [15:0] glyph_base_q;
	logic [23:0] pix_q;
	logic [ROW_W-1:0] row_q;
	logic [15:0] rd_sum;
	logic [31:0] y_times_stride;

	logic [7:0]  font_mem [FONT_BYTES];

	logic        v_s1;
	logic [7:0]  mask_s1;
	logic [23:0] idx_s1;
	logic        last_s1;
	logic        move;

	logic        v_q;
	logic [7:0]  mask_q;
	logic [23:0] idx_q;
	logic        last_q;

	assign x_adv          = cursor_x_q + 16'(GLYPH_COLS);
	assign rd_sum         = glyph_base_q + 16'(row_q);
	assign y_times_stride = cursor_y_q * line_stride_q;
	assign move           = v_s1 && (!v_q || out_ready);

	assign status.slot_free = !v_s1 || move;
	assign status.row_last  = (row_q == ROW_W'(GLYPH_ROWS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q       <= COLOUR_RESET;
			screen_width_q <= SCREEN_WIDTH_RESET;
			line_stride_q  <= LINE_STRIDE_RESET;
			glyph_stride_q <= GLYPH_STRIDE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLOUR:       colour_q       <= cfg_data;
				REG_SCREEN_WIDTH: screen_width_q <= cfg_data[15:0];
				REG_LINE_STRIDE:  line_stride_q  <= cfg_data[15:0];
				REG_GLYPH_STRIDE: glyph_stride_q <= cfg_data[7:0];
				default:          colour_q       <= colour_q;
			endcase
		end
	end

	// The cursor moves on a newline and on the setup cycle of a drawn character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (cmd.newline) begin
			cursor_x_q <= '0;
			cursor_y_q <= cursor_y_q + 16'(GLYPH_ROWS);
		end else if (cmd.setup) begin
			if (x_adv > screen_width_q) begin
				cursor_x_q <= '0;
				cursor_y_q <= cursor_y_q + 16'(GLYPH_ROWS);
			end else begin
				cursor_x_q <= x_adv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			char_q <= in_character;
		end
		if (cmd.setup) begin
			glyph_base_q <= char_q * glyph_stride_q;
			pix_q        <= 24'(cursor_x_q) + y_times_stride[23:0];
			row_q        <= '0;
		end else if (cmd.issue) begin
			pix_q <= pix_q + 24'(line_stride_q);
			row_q <= row_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.font_wr) begin
			font_mem[in_font_address[FONT_AW-1:0]] <= in_font_byte;
		end
		if (cmd.issue) begin
			mask_s1 <= font_mem[rd_sum[FONT_AW-1:0]];
			idx_s1  <= pix_q;
			last_s1 <= status.row_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (cmd.issue) begin
				v_s1 <= 1'b1;
			end else if (move) begin
				v_s1 <= 1'b0;
			end
			if (move) begin
				v_q <= 1'b1;
			end else if (out_ready) begin
				v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			mask_q <= mask_s1;
			idx_q  <= idx_s1;
			last_q <= last_s1;
		end
	end

	assign out_valid        = v_q;
	assign out_pixel_index  = idx_q;
	assign out_pixel_mask   = mask_q;
	assign out_pixel_colour = colour_q;
	assign out_last_row     = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/bitmap_font_text_renderer.sv
// A drawn character is accepted, passes a setup state and then has its rows
// read and shown one row per cycle while the output is taken.
// Each drawn character needs 16 row reads on the single font store read port and
// holds off new items until its last read is issued; font writes and newlines do not.
// Reset: cursor and configuration return to defaults; the font store is
// undefined until written and gets no clearing pass.
// ----------------------------------------------------------------------------
// Bitmap font text renderer
// Stores glyph bytes and turns drawn characters into masked pixel row writes.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_font_text_renderer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bftr_in_if.sink                          in_ch,
	bftr_out_if.source                       out_ch,
	input  wire logic                        cfg_we,
	input  wire logic [bftr_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [bftr_pkg::CFG_DW-1:0] cfg_data
);
	import bftr_pkg::*;

	// The controller decodes each accepted item. A font write goes straight
	// into the font store, and a newline only moves the cursor. A character
	// to draw is latched, the setup cycle forms its glyph base address and
	// the pixel index of its top row, and the row state then issues one font
	// read per cycle whenever the read stage has room.
	bftr_cmd_t    cmd;
	bftr_status_t status;

	bftr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.in_opcode    (in_ch.opcode),
		.in_character (in_ch.character),
		.status       (status),
		.cmd          (cmd)
	);

	// The datapath holds the registered read stage and an output register,
	// so a stalled result holds while the next rows wait behind it, and the
	// next item can be taken while the last rows still drain.
	bftr_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_character     (in_ch.character),
		.in_font_address  (in_ch.font_address),
		.in_font_byte     (in_ch.font_byte),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_pixel_index  (out_ch.pixel_index),
		.out_pixel_mask   (out_ch.pixel_mask),
		.out_pixel_colour (out_ch.pixel_colour),
		.out_last_row     (out_ch.last_row)
	);

endmodule

`default_nettype wire

// File: tb/sv/bftr_row_checker.sv
// ----------------------------------------------------------------------------
// Bitmap font text renderer row checker
// Watches both channels and the register port, predicts the pixel row items
// of every drawn character and compares them with what the block emits.
// ----------------------------------------------------------------------------

module bftr_row_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bftr_in_if                               in_mon,
	bftr_out_if                              out_mon,
	input  wire logic                        cfg_we,
	input  wire logic [bftr_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [bftr_pkg::CFG_DW-1:0] cfg_data,
	output int                               fail_count,
	output int                               rows_outstanding
);
	import bftr_pkg::*;

	typedef struct packed {
		logic [23:0] pixel_index;
		logic [7:0]  pixel_mask;
		logic [31:0] pixel_colour;
		logic        last_row;
	} glyph_row_t;

	logic [31:0] colour;
	logic [15:0] screen_width;
	logic [15:0] line_stride;
	logic [7:0]  glyph_stride;
	logic [15:0] cursor_x;
	logic [15:0] cursor_y;
	logic [7:0]  font_image [FONT_BYTES];
	glyph_row_t  expected_rows [$];
	int          reported;

	function automatic void next_text_line();
		cursor_x = '0;
		cursor_y = cursor_y + 16'(GLYPH_ROWS);
	endfunction

	// The row's y is formed before truncation, so a large stride still lands
	// in the low 24 bits exactly as the block computes it.
	function automatic void render_character(input logic [7:0] code);
		logic [31:0] base;
		logic [31:0] addr;
		logic [31:0] row_y;
		logic [47:0] start;
		glyph_row_t  row;
		base = 32'(code) * 32'(glyph_stride);
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			row_y = 32'(cursor_y) + 32'(r);
			start = 48'(cursor_x) + 48'(row_y) * 48'(line_stride);
			addr = base + 32'(r);
			row.pixel_index = start[23:0];
			row.pixel_mask = font_image[addr[FONT_AW-1:0]];
			row.pixel_colour = colour;
			row.last_row = (r == GLYPH_ROWS - 1);
			expected_rows.push_back(row);
		end
		cursor_x = cursor_x + 16'(GLYPH_COLS);
		if (cursor_x > screen_width) begin
			next_text_line();
		end
	endfunction

	function automatic void check_row(input glyph_row_t got);
		glyph_row_t want;
		if (expected_rows.size() == 0) begin
			fail_count++;
			if (reported < 10) begin
				reported++;
				$display("unexpected row item: index %h mask %h colour %h last %b",
					got.pixel_index, got.pixel_mask, got.pixel_colour, got.last_row);
			end
		end else begin
			want = expected_rows.pop_front();
			if (got.pixel_index !== want.pixel_index || got.pixel_mask !== want.pixel_mask
				|| got.pixel_colour !== want.pixel_colour
				|| got.last_row !== want.last_row) begin
				fail_count++;
				if (reported < 10) begin
					reported++;
					$display("row mismatch: expected index %h mask %h colour %h last %b",
						want.pixel_index, want.pixel_mask, want.pixel_colour,
						want.last_row);
					$display("              actual   index %h mask %h colour %h last %b",
						got.pixel_index, got.pixel_mask, got.pixel_colour, got.last_row);
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour = COLOUR_RESET;
			screen_width = SCREEN_WIDTH_RESET;
			line_stride = LINE_STRIDE_RESET;
			glyph_stride = GLYPH_STRIDE_RESET;
			cursor_x = '0;
			cursor_y = '0;
			expected_rows.delete();
			fail_count = 0;
			reported = 0;
			rows_outstanding = 0;
		end else begin
			// Results are checked before the new item is predicted, so a row
			// can never be matched against an expectation made in its own cycle.
			if (out_mon.valid && out_mon.ready) begin
				check_row({out_mon.pixel_index, out_mon.pixel_mask, out_mon.pixel_colour,
					out_mon.last_row});
			end
			if (in_mon.valid && in_mon.ready) begin
				if (in_mon.opcode == OP_FONT_WRITE) begin
					font_image[in_mon.font_address] = in_mon.font_byte;
				end else if (in_mon.character == CHAR_NEWLINE) begin
					next_text_line();
				end else begin
					render_character(in_mon.character);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_COLOUR: begin
						colour = cfg_data;
					end
					REG_SCREEN_WIDTH: begin
						screen_width = cfg_data[15:0];
					end
					REG_LINE_STRIDE: begin
						line_stride = cfg_data[15:0];
					end
					REG_GLYPH_STRIDE: begin
						glyph_stride = cfg_data[7:0];
					end
					default: begin
					end
				endcase
			end
			rows_outstanding = expected_rows.size();
		end
	end

endmodule

// File: tb/sv/tb_bitmap_font_text_renderer.sv
// ----------------------------------------------------------------------------
// Bitmap font text renderer testbench
// Loads glyphs into the font store and draws characters under several register
// settings, with random stalls on both channels; a row checker beside the
// block predicts every pixel row item and counts mismatches.
// ----------------------------------------------------------------------------

module tb_bitmap_font_text_renderer;

	import bftr_pkg::*;

	// Generous cap on the whole run, in clock cycles, meant to hold even when
	// every row of every character meets the longest output stall.
	localparam int LIMIT_CYCLES = 200000;
	// Length of the single long hold-off on the result side.
	localparam int HOLD_CYCLES = 300;
	// Row bits for the directed glyph: empty row, full row, single edge
	// pixels and assorted patterns, first row in the low byte.
	localparam logic [127:0] GLYPH_PATTERNS =
		128'h99_3C_C3_7E_81_42_24_18_0F_F0_55_AA_01_80_FF_00;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	int                fail_count;
	int                rows_outstanding;

	// Stimulus bookkeeping. The font store holds garbage until written, so
	// every byte that a draw will read must have been written beforehand.
	bit                font_written [FONT_BYTES];
	logic [7:0]        stride_now;
	int                items_sent;
	bit                idling;
	bit                hold_request;
	bit                hold_done;

	bftr_in_if  in_bus();
	bftr_out_if out_bus();

	bitmap_font_text_renderer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_bus),
		.out_ch    (out_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bftr_row_checker row_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_mon           (in_bus),
		.out_mon          (out_bus),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.rows_outstanding (rows_outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Font store address of one glyph row under the current glyph stride;
	// the read wraps around the end of the store.
	function automatic logic [FONT_AW-1:0] glyph_address(input logic [7:0] code,
		input int r);
		int a;
		a = (int'(code) * int'(stride_now) + r) % FONT_BYTES;
		return a[FONT_AW-1:0];
	endfunction

	// A character may be drawn only when all of its rows have been written.
	function automatic bit glyph_loaded(input logic [7:0] code);
		bit ok;
		ok = 1'b1;
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			if (!font_written[glyph_address(code, r)]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	function automatic logic [7:0] pick_glyph_code();
		logic [7:0] code;
		do begin
			code = 8'($urandom);
		end while (code == CHAR_NEWLINE);
		return code;
	endfunction

	// Row bits lean toward the empty and the full row now and then.
	function automatic logic [7:0] random_row_bits();
		case ($urandom_range(0, 5))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	// Offers one item, optionally after a short gap, and returns at the
	// falling edge after the item was accepted. Valid stays high so that
	// back-to-back items follow each other without a gap.
	task automatic send_item(input logic op, input logic [7:0] code,
		input logic [FONT_AW-1:0] addr, input logic [7:0] data);
		if (idling && $urandom_range(0, 5) == 0) begin
			in_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.opcode <= op;
		in_bus.character <= code;
		in_bus.font_address <= addr;
		in_bus.font_byte <= data;
		do begin
			@(posedge clk);
		end while (!in_bus.ready);
		@(negedge clk);
		if (op == OP_FONT_WRITE) begin
			font_written[addr] = 1'b1;
		end
		items_sent++;
	endtask

	// A draw carries random address and byte fields, which the block ignores.
	task automatic send_draw(input logic [7:0] code);
		send_item(OP_DRAW, code, FONT_AW'($urandom), 8'($urandom));
	endtask

	task automatic send_newline();
		send_item(OP_DRAW, CHAR_NEWLINE, FONT_AW'($urandom), 8'($urandom));
	endtask

	// Writes the first rows of a glyph. Rows already written are skipped
	// unless they are to be rewritten with fresh content.
	task automatic load_glyph(input logic [7:0] code, input int rows, input bit rewrite);
		logic [FONT_AW-1:0] a;
		for (int r = 0; r < rows; r++) begin
			a = glyph_address(code, r);
			if (rewrite || !font_written[a]) begin
				send_item(OP_FONT_WRITE, 8'($urandom), a, random_row_bits());
			end
		end
	endtask

	// Register writes only happen with the block idle; the write enable is
	// raised once and held across all four registers.
	task automatic program_regs(input logic [31:0] colour, input logic [15:0] width,
		input logic [15:0] stride, input logic [7:0] glyph_bytes);
		cfg_we <= 1'b1;
		cfg_index <= REG_COLOUR;
		cfg_data <= colour;
		@(negedge clk);
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= CFG_DW'(width);
		@(negedge clk);
		cfg_index <= REG_LINE_STRIDE;
		cfg_data <= CFG_DW'(stride);
		@(negedge clk);
		cfg_index <= REG_GLYPH_STRIDE;
		cfg_data <= CFG_DW'(glyph_bytes);
		@(negedge clk);
		cfg_we <= 1'b0;
		stride_now = glyph_bytes;
	endtask

	// Waits until every predicted row has come back and then for the block to
	// settle, so that a trailing newline or font write has taken effect too.
	task automatic drain_results();
		in_bus.valid <= 1'b0;
		while (rows_outstanding != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	// Random traffic. Most of it loads a glyph and draws it a few times; the
	// rest is newlines, redraws of glyphs loaded earlier, stray font writes
	// and glyphs that are only partly written and never drawn.
	task automatic run_random(input int count);
		int         target;
		int         pick;
		bit         found;
		logic [7:0] code;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				idling = !idling;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				code = pick_glyph_code();
				load_glyph(code, GLYPH_ROWS, $urandom_range(0, 3) == 0);
				repeat ($urandom_range(1, 3)) send_draw(code);
			end else if (pick < 67) begin
				send_newline();
			end else if (pick < 80) begin
				found = 1'b0;
				for (int t = 0; t < 8 && !found; t++) begin
					code = pick_glyph_code();
					found = glyph_loaded(code);
				end
				if (found) begin
					send_draw(code);
				end
			end else if (pick < 90) begin
				send_item(OP_FONT_WRITE, 8'($urandom), FONT_AW'($urandom), random_row_bits());
			end else begin
				load_glyph(pick_glyph_code(), $urandom_range(1, GLYPH_ROWS - 1), 1'b1);
			end
		end
	endtask

	// Result side: short random stalls while idling is on, plus one long
	// hold-off on request during which the sender keeps offering items.
	initial begin
		out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				out_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				out_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(negedge clk);
			end else begin
				out_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [7:0] code;
		arst_n = 1'b0;
		in_bus.valid = 1'b0;
		in_bus.opcode = OP_FONT_WRITE;
		in_bus.character = '0;
		in_bus.font_address = '0;
		in_bus.font_byte = '0;
		cfg_we = 1'b0;
		cfg_index = REG_COLOUR;
		cfg_data = '0;
		stride_now = GLYPH_STRIDE_RESET;
		items_sent = 0;
		idling = 1'b1;
		hold_request = 1'b0;
		hold_done = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset settings. Glyph 255 sits at the very
		// top of the store, so its last row uses the highest font address.
		// The rows include an empty one, a full one and single edge pixels.
		for (int r = 0; r < GLYPH_ROWS; r++) begin
			send_item(OP_FONT_WRITE, 8'(r), glyph_address(8'hFF, r),
				GLYPH_PATTERNS[r*8 +: 8]);
		end
		send_draw(8'hFF);
		send_item(OP_DRAW, CHAR_NEWLINE, '1, 8'hFF);
		send_draw(8'hFF);
		// A font write whose character field holds the newline code is still
		// only a font write.
		send_item(OP_FONT_WRITE, CHAR_NEWLINE, '0, 8'h00);
		drain_results();

		// Stride 195 puts glyph 21 at the last byte of the store, so its rows
		// wrap around to address 0. The result side then holds off for a
		// long stretch while the draws keep coming, which backs up the block.
		program_regs($urandom, 16'($urandom_range(8, 2000)),
			16'($urandom_range(1, 4000)), 8'd195);
		load_glyph(8'd21, GLYPH_ROWS, 1'b1);
		hold_request = 1'b1;
		repeat (4) send_draw(8'd21);
		run_random(65);
		drain_results();

		// Upper extremes of every register: the pixel index overflows 24 bits
		// and almost every glyph address wraps around the store.
		program_regs('1, '1, '1, '1);
		run_random(65);
		drain_results();

		// Lower extremes: every character reads the same sixteen bytes, all
		// rows land on the same pixel, and each character wraps the line.
		program_regs('0, '0, '0, '0);
		load_glyph(8'h00, GLYPH_ROWS, 1'b1);
		send_draw(8'h00);
		run_random(65);
		drain_results();

		// Last part, with no idling on either side: a narrow screen makes the
		// column wrap every few characters while items follow each other.
		idling = 1'b0;
		program_regs($urandom, 16'($urandom_range(8, 200)), 16'($urandom),
			8'($urandom));
		code = pick_glyph_code();
		load_glyph(code, GLYPH_ROWS, 1'b0);
		send_newline();
		repeat (30) send_draw(code);
		drain_results();

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#(2 * LIMIT_CYCLES);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/bftr_pkg.sv
hw/rtl/bftr_channels.sv
hw/rtl/bftr_ctrl.sv
hw/rtl/bftr_datapath.sv
hw/rtl/bitmap_font_text_renderer.sv
tb/sv/bftr_row_checker.sv
tb/sv/tb_bitmap_font_text_renderer.sv
